@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its cause.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/gbli_pkg.sv @@
// Types and constants of the grid bracket linear interpolator.
`default_nettype none

package gbli_pkg;

   localparam int MAX_ENTRIES_DEF = 1024;
   localparam int POINT_WIDTH_DEF = 32;

   localparam int ENTRY_INDEX_W = 10;
   localparam int POINT_FIELD_W = 32;
   localparam int VALUE_W       = 32;
   localparam int FRAC_W        = 17;
   localparam int COUNT_W       = 11;
   localparam int DIV_STEPS     = 16;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   localparam logic REG_ENTRY_COUNT = 1'b0;
   localparam logic REG_CHECK_ORDER = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = '0;
   localparam logic               CHECK_RESET = 1'b1;

   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

   typedef struct packed {
      logic                             operation;
      logic        [ENTRY_INDEX_W-1:0]  entry_index;
      logic        [POINT_FIELD_W-1:0]  grid_point;
      logic signed [VALUE_W-1:0]        sample_value;
      logic        [POINT_FIELD_W-1:0]  query_point;
   } req_type;

   typedef struct packed {
      logic                             status;
      logic        [ENTRY_INDEX_W-1:0]  bracket_index;
      logic        [FRAC_W-1:0]         fraction;
      logic signed [VALUE_W-1:0]        interp_value;
   } rsp_type;

endpackage

`default_nettype wire

@@ src/gbli_ram.sv @@
// Single-port RAM with registered read data.
`default_nettype none

module gbli_ram #(
   parameter int WIDTH = gbli_pkg::POINT_FIELD_W,
   parameter int DEPTH = gbli_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ src/grid_bracket_linear_interp.sv @@
// Top level of the grid bracket linear interpolator.
//
// Usage:
//   Items enter on req_item and are taken at a clock edge with start high and busy low.
//   A load item writes one point/value pair into the table and checks the order
//   against the slot below. A query item searches the table, divides for the
//   Q1.16 fraction and multiplies for the interpolated value.
//   Every item gives one result beat on rsp_item, marked by rsp_valid for
//   exactly one cycle. The receiver cannot stall; the beat is taken as shown.
//   An error or an ignored load is answered from the idle state; a load reads
//   the slot below (none for index 0) and then writes; a query that clamps
//   skips the search and the divide, and an interior query takes k search steps,
//   k <= ceil(log2(n - 1)), before the divide and the multiply. Each search
//   step costs one read of the single-port point memory, and the divider
//   retires one quotient bit per cycle. One item is in work at a time; a new
//   item may be started in the cycle of the result beat.
//   Registers (APB, byte addresses 0 and 4): entry_count, check_order.
//   Reset clears the sequencer and the order fault, sets entry_count to 0 and
//   check_order to 1; table contents stay undefined until loaded.
`default_nettype none

module grid_bracket_linear_interp #(
   parameter int MAX_ENTRIES = gbli_pkg::MAX_ENTRIES_DEF,
   parameter int POINT_WIDTH = gbli_pkg::POINT_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire gbli_pkg::req_type                   req_item,
   output logic                                     rsp_valid,
   output gbli_pkg::rsp_type                        rsp_item,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [gbli_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [gbli_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [gbli_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                     pready
);

   import gbli_pkg::*;

   `include "assert_macros.svh"

   localparam int AW  = $clog2(MAX_ENTRIES);
   localparam int NW  = $clog2(MAX_ENTRIES + 1);
   localparam int PTW = (POINT_WIDTH < POINT_FIELD_W) ? POINT_WIDTH : POINT_FIELD_W;
   localparam int CW  = $clog2(DIV_STEPS);

   typedef enum logic [17:0] {
      S_IDLE     = 18'h00001,
      S_LD_RD    = 18'h00002,
      S_LD_WR    = 18'h00004,
      S_Q_P0     = 18'h00008,
      S_Q_PN     = 18'h00010,
      S_Q_TOP    = 18'h00020,
      S_SRCH_RD  = 18'h00040,
      S_SRCH_CMP = 18'h00080,
      S_BR_HI    = 18'h00100,
      S_BR_CHK   = 18'h00200,
      S_DIV_D    = 18'h00400,
      S_DIV_SAT  = 18'h00800,
      S_DIV      = 18'h01000,
      S_V_LO     = 18'h02000,
      S_V_HI     = 18'h04000,
      S_V_DLT    = 18'h08000,
      S_V_MUL    = 18'h10000,
      S_V_SUM    = 18'h20000
   } state_type;

   state_type             state_ff, state_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  check_ff, check_in;
   logic                  fault_ff, fault_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   req_type               req_ff, req_in;
   rsp_type               rsp_ff, rsp_in;
   logic [AW-1:0]         lo_ff, lo_in;
   logic [AW-1:0]         hi_ff, hi_in;
   logic [AW-1:0]         mid_ff, mid_in;
   logic [PTW-1:0]        base_ff, base_in;
   logic [PTW-1:0]        div_ff, div_in;
   logic [PTW-1:0]        rem_ff, rem_in;
   logic [FRAC_W-1:0]     frac_ff, frac_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [VALUE_W-1:0]    vlo_ff, vlo_in;
   logic signed [VALUE_W:0]        delta_ff, delta_in;
   logic signed [VALUE_W+FRAC_W:0] prod_ff, prod_in;

   logic                  accept;
   logic                  csr_write;
   logic [NW-1:0]         n_cnt;
   logic [AW-1:0]         n_less1;
   logic [AW-1:0]         n_less2;
   logic [AW:0]           span;
   logic [AW-1:0]         mid;
   logic [PTW-1:0]        q_pt;
   logic [PTW-1:0]        ld_pt;
   logic                  ld_in_range;

   logic [PTW:0]          alu_a;
   logic [PTW:0]          alu_b;
   logic [PTW+1:0]        alu_diff;
   logic                  alu_borrow;
   logic                  alu_zero;

   logic [AW-1:0]         ram_addr;
   logic                  ram_we;
   logic [PTW-1:0]        p_rdata;
   logic [VALUE_W-1:0]    v_rdata;

   gbli_ram #(
      .WIDTH (PTW),
      .DEPTH (MAX_ENTRIES)
   ) u_point_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ld_pt),
      .rdata (p_rdata)
   );

   gbli_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ENTRIES)
   ) u_value_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_ff.sample_value),
      .rdata (v_rdata)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      case (paddr[2])
         REG_ENTRY_COUNT: prdata = CSR_DATA_W'(count_ff);
         REG_CHECK_ORDER: prdata = CSR_DATA_W'(check_ff);
         default:         prdata = '0;
      endcase
   end

   always_comb begin
      if (32'(count_ff) > 32'(MAX_ENTRIES)) begin
         n_cnt = NW'(MAX_ENTRIES);
      end else begin
         n_cnt = NW'(count_ff);
      end
   end

   assign n_less1     = AW'(n_cnt - NW'(1));
   assign n_less2     = AW'(n_cnt - NW'(2));
   assign span        = {1'b0, hi_ff} - {1'b0, lo_ff} + (AW+1)'(1);
   assign mid         = lo_ff + span[AW:1];
   assign q_pt        = req_ff.query_point[PTW-1:0];
   assign ld_pt       = req_ff.grid_point[PTW-1:0];
   assign ld_in_range = (32'(req_item.entry_index) < 32'(MAX_ENTRIES));

   // shared subtractor for compares and divider steps
   always_comb begin
      case (state_ff)
         S_LD_WR: begin
            alu_a = {1'b0, p_rdata};
            alu_b = {1'b0, ld_pt};
         end
         S_Q_PN: begin
            alu_a = {1'b0, p_rdata};
            alu_b = {1'b0, q_pt};
         end
         S_Q_TOP, S_SRCH_CMP: begin
            alu_a = {1'b0, q_pt};
            alu_b = {1'b0, p_rdata};
         end
         S_BR_CHK: begin
            alu_a = {1'b0, p_rdata};
            alu_b = {1'b0, base_ff};
         end
         S_DIV_D: begin
            alu_a = {1'b0, q_pt};
            alu_b = {1'b0, base_ff};
         end
         S_DIV_SAT: begin
            alu_a = {1'b0, rem_ff};
            alu_b = {1'b0, div_ff};
         end
         S_DIV: begin
            alu_a = {rem_ff, 1'b0};
            alu_b = {1'b0, div_ff};
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_borrow = alu_diff[PTW+1];
   assign alu_zero   = (alu_diff == '0);

   always_comb begin
      ram_we = 1'b0;
      case (state_ff)
         S_LD_RD:   ram_addr = AW'(req_ff.entry_index - ENTRY_INDEX_W'(1));
         S_LD_WR: begin
            ram_addr = AW'(req_ff.entry_index);
            ram_we   = 1'b1;
         end
         S_Q_P0:    ram_addr = '0;
         S_Q_PN:    ram_addr = n_less1;
         S_SRCH_RD: ram_addr = (lo_ff < hi_ff) ? mid : lo_ff;
         S_BR_HI:   ram_addr = lo_ff + AW'(1);
         S_V_HI:    ram_addr = lo_ff + AW'(1);
         default:   ram_addr = lo_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      check_in     = check_ff;
      fault_in     = fault_ff;
      rsp_valid_in = 1'b0;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      base_in      = base_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      frac_in      = frac_ff;
      cnt_in       = cnt_ff;
      vlo_in       = vlo_ff;
      delta_in     = delta_ff;
      prod_in      = prod_ff;

      if (csr_write) begin
         case (paddr[2])
            REG_ENTRY_COUNT: count_in = pwdata[COUNT_W-1:0];
            REG_CHECK_ORDER: check_in = pwdata[0];
            default:         count_in = count_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_item;
               rsp_in = '0;
               if (req_item.operation == OP_LOAD) begin
                  if (!ld_in_range) begin
                     rsp_in.status = fault_ff;
                     rsp_valid_in  = 1'b1;
                  end else if (req_item.entry_index == '0) begin
                     state_in = S_LD_WR;
                  end else begin
                     state_in = S_LD_RD;
                  end
               end else if (n_cnt < NW'(2) || (check_ff && fault_ff)) begin
                  rsp_in.status = STATUS_ERR;
                  rsp_valid_in  = 1'b1;
               end else begin
                  state_in = S_Q_P0;
               end
            end
         end
         S_LD_RD: state_in = S_LD_WR;
         S_LD_WR: begin
            fault_in      = fault_ff || (req_ff.entry_index != '0 && !alu_borrow);
            rsp_in        = '0;
            rsp_in.status = fault_in;
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end
         S_Q_P0: state_in = S_Q_PN;
         S_Q_PN: begin
            if (!alu_borrow) begin
               lo_in    = '0;
               frac_in  = '0;
               state_in = S_V_LO;
            end else begin
               state_in = S_Q_TOP;
            end
         end
         S_Q_TOP: begin
            if (!alu_borrow) begin
               lo_in    = n_less2;
               frac_in  = FRAC_ONE;
               state_in = S_V_LO;
            end else begin
               lo_in    = '0;
               hi_in    = n_less2;
               state_in = S_SRCH_RD;
            end
         end
         S_SRCH_RD: begin
            mid_in   = mid;
            state_in = (lo_ff < hi_ff) ? S_SRCH_CMP : S_BR_HI;
         end
         S_SRCH_CMP: begin
            if (!alu_borrow) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff - AW'(1);
            end
            state_in = S_SRCH_RD;
         end
         S_BR_HI: begin
            base_in  = p_rdata;
            state_in = S_BR_CHK;
         end
         S_BR_CHK: begin
            div_in = alu_diff[PTW-1:0];
            if (alu_borrow || alu_zero) begin
               frac_in  = '0;
               state_in = S_V_LO;
            end else begin
               state_in = S_DIV_D;
            end
         end
         S_DIV_D: begin
            rem_in = alu_diff[PTW-1:0];
            if (alu_borrow) begin
               frac_in  = '0;
               state_in = S_V_LO;
            end else begin
               state_in = S_DIV_SAT;
            end
         end
         S_DIV_SAT: begin
            cnt_in  = '0;
            frac_in = '0;
            if (!alu_borrow) begin
               frac_in  = FRAC_ONE;
               state_in = S_V_LO;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!alu_borrow) begin
               rem_in = alu_diff[PTW-1:0];
            end else begin
               rem_in = {rem_ff[PTW-2:0], 1'b0};
            end
            frac_in = {frac_ff[FRAC_W-2:0], !alu_borrow};
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DIV_STEPS - 1)) begin
               state_in = S_V_LO;
            end
         end
         S_V_LO: state_in = S_V_HI;
         S_V_HI: begin
            vlo_in   = v_rdata;
            state_in = S_V_DLT;
         end
         S_V_DLT: begin
            delta_in = {v_rdata[VALUE_W-1], v_rdata} - {vlo_ff[VALUE_W-1], vlo_ff};
            state_in = S_V_MUL;
         end
         S_V_MUL: begin
            prod_in  = $signed({1'b0, frac_ff}) * delta_ff;
            state_in = S_V_SUM;
         end
         S_V_SUM: begin
            rsp_in.status        = STATUS_OK;
            rsp_in.bracket_index = ENTRY_INDEX_W'(lo_ff);
            rsp_in.fraction      = frac_ff;
            rsp_in.interp_value  = vlo_ff + prod_ff[VALUE_W+15:16];
            rsp_valid_in         = 1'b1;
            state_in             = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= COUNT_RESET;
         check_ff     <= CHECK_RESET;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         check_ff     <= check_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      base_ff  <= base_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      frac_ff  <= frac_in;
      cnt_ff   <= cnt_in;
      vlo_ff   <= vlo_in;
      delta_ff <= delta_in;
      prod_ff  <= prod_in;
   end

   `ASSERT_ALWAYS(a_state_onehot, clock, reset, $onehot(state_ff), "state not one-hot")
   `ASSERT_NEXT(a_accept_progress, clock, reset, accept, busy || rsp_valid,
      "accepted item neither in work nor answered")
   `ASSERT_NEXT(a_fault_sticky, clock, reset, fault_ff, fault_ff, "order fault cleared")
   `ASSERT_SAME(a_frac_range, clock, reset, rsp_valid, rsp_item.fraction <= FRAC_ONE,
      "fraction above one")
   `ASSERT_SAME(a_error_zero, clock, reset, rsp_valid && rsp_item.status == STATUS_ERR,
      rsp_item.fraction == '0 && rsp_item.interp_value == '0 && rsp_item.bracket_index == '0,
      "error beat with nonzero payload")

endmodule

`default_nettype wire
